// ===== src/skt_pkg.sv =====
package skt_pkg;

  // Table size and the widths that follow from it.
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // Field widths of the request and response beats.
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned ECNT_W   = 5;

  // Width used to compare a position against the fill count.
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 3'd0,
    ACT_DELETE = 3'd1,
    ACT_FIND   = 3'd2,
    ACT_NTH    = 3'd3,
    ACT_LAST   = 3'd4
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_EXISTS  = 3'd1,
    ST_MISSING = 3'd2,
    ST_FULL    = 3'd3,
    ST_BAD     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_FETCH,
    S_SHUP,
    S_WRNEW,
    S_SHDN,
    S_DONE
  } seq_state_e;

  // One stored key/info pair, as it sits in a word of the table memory.
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic signed [KEY_W-1:0] payload;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // One finished result on its way to the output register.
  typedef struct packed {
    status_e                 status;
    logic signed [KEY_W-1:0] key;
    logic signed [KEY_W-1:0] payload;
    logic [ECNT_W-1:0]       count;
  } result_t;

endpackage

// ===== src/skt_req_if.sv =====
interface skt_req_if;
  logic                                    valid;
  logic                                    ready;
  logic [skt_pkg::ACTION_W-1:0]            action;
  logic signed [skt_pkg::KEY_W-1:0]        key;
  logic signed [skt_pkg::KEY_W-1:0]        payload;
  logic [skt_pkg::POS_W-1:0]               position;

  modport source (output valid, action, key, payload, position, input ready);
  modport sink   (input valid, action, key, payload, position, output ready);
endinterface

// ===== src/skt_rsp_if.sv =====
interface skt_rsp_if;
  logic                                    valid;
  logic                                    ready;
  logic [skt_pkg::STATUS_W-1:0]            status;
  logic signed [skt_pkg::KEY_W-1:0]        found_key;
  logic signed [skt_pkg::KEY_W-1:0]        found_payload;
  logic [skt_pkg::ECNT_W-1:0]              entry_count;

  modport source (output valid, status, found_key, found_payload, entry_count, input ready);
  modport sink   (input valid, status, found_key, found_payload, entry_count, output ready);
endinterface

// ===== src/sorted_key_table.sv =====
// Sorted key table: holds up to CAPACITY unique signed keys, each with a 32-bit
// info word, in ascending key order in one single-port-read, single-port-write
// memory. Each request beat inserts, deletes, finds by key, fetches the n-th
// entry or fetches the last entry, and yields exactly one response beat with a
// status, the matched pair and the fill count after the operation. Requests are
// handled one at a time. A position or last-entry fetch reads the memory and
// captures the entry in S_FETCH; a rejected one goes straight to S_DONE. Key
// operations scan the table one entry per cycle until the first key not below
// the request key, then an insert moves the entries from its slot upward, or a
// delete the entries above the removed slot downward, by one place, again one
// per cycle. The memory's single read port sets both the scan and the shift
// rate. The output register lets a new request in while the previous response
// still waits to be taken. The memory needs no clearing after reset: only slots
// below the fill count are ever read.
module sorted_key_table (
  input  logic      clk_i,
  input  logic      rst_ni,
  skt_req_if.sink   req_i,
  skt_rsp_if.source rsp_o
);

  logic                      ram_we;
  logic [skt_pkg::IDX_W-1:0] ram_waddr;
  skt_pkg::entry_t           ram_wdata;
  logic                      ram_re;
  logic [skt_pkg::IDX_W-1:0] ram_raddr;
  skt_pkg::entry_t           ram_rdata;
  logic                      res_valid;
  logic                      res_ready;
  skt_pkg::result_t          res;

  // Table memory.
  skt_ram #(
    .WIDTH (skt_pkg::ENTRY_W),
    .DEPTH (skt_pkg::CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Operation sequencer.
  skt_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Response register.
  skt_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .rsp_o       (rsp_o)
  );

endmodule

// ===== src/skt_ram.sv =====
module skt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/skt_seq.sv =====
module skt_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  skt_req_if.sink                     req_i,
  // Table memory access.
  output logic                        ram_we_o,
  output logic [skt_pkg::IDX_W-1:0]   ram_waddr_o,
  output skt_pkg::entry_t             ram_wdata_o,
  output logic                        ram_re_o,
  output logic [skt_pkg::IDX_W-1:0]   ram_raddr_o,
  input  skt_pkg::entry_t             ram_rdata_i,
  // Finished result towards the output register.
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output skt_pkg::result_t            res_o
);

  localparam int unsigned IDX_W = skt_pkg::IDX_W;
  localparam int unsigned CNT_W = skt_pkg::CNT_W;
  localparam int unsigned CMP_W = skt_pkg::CMP_W;
  localparam int unsigned POS_W = skt_pkg::POS_W;
  localparam int unsigned KEY_W = skt_pkg::KEY_W;

  skt_pkg::seq_state_e     state_q, state_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [IDX_W-1:0]        ptr_q, ptr_d;
  logic [CNT_W-1:0]        slot_q, slot_d;
  logic                    hit_q, hit_d;
  skt_pkg::action_e        act_q, act_d;
  logic signed [KEY_W-1:0] key_q, key_d;
  logic signed [KEY_W-1:0] pay_q, pay_d;
  skt_pkg::status_e        status_q, status_d;
  logic signed [KEY_W-1:0] fkey_q, fkey_d;
  logic signed [KEY_W-1:0] fpay_q, fpay_d;

  logic [POS_W-1:0]        pos_eff;
  logic [CNT_W-1:0]        ptr_ext;
  logic [CNT_W-1:0]        last_cnt;

  // Position zero is read as the first entry.
  assign pos_eff  = (req_i.position == '0) ? POS_W'(1) : req_i.position;
  assign ptr_ext  = CNT_W'(ptr_q);
  assign last_cnt = count_q - CNT_W'(1);

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= skt_pkg::S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Working registers of the item in flight.
  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    slot_q   <= slot_d;
    hit_q    <= hit_d;
    act_q    <= act_d;
    key_q    <= key_d;
    pay_q    <= pay_d;
    status_q <= status_d;
    fkey_q   <= fkey_d;
    fpay_q   <= fpay_d;
  end

  // Sequencer: fetch by position, or scan for the key's slot, then shift entries one per cycle.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    slot_d      = slot_q;
    hit_d       = hit_q;
    act_d       = act_q;
    key_d       = key_q;
    pay_d       = pay_q;
    status_d    = status_q;
    fkey_d      = fkey_q;
    fpay_d      = fpay_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = '0;
    ram_wdata_o = '0;
    ram_re_o    = 1'b0;
    ram_raddr_o = '0;
    req_i.ready = (state_q == skt_pkg::S_IDLE);
    res_valid_o = (state_q == skt_pkg::S_DONE);

    case (state_q)
      skt_pkg::S_IDLE: begin
        if (req_i.valid) begin
          act_d  = skt_pkg::action_e'(req_i.action);
          key_d  = req_i.key;
          pay_d  = req_i.payload;
          fkey_d = '0;
          fpay_d = '0;
          case (skt_pkg::action_e'(req_i.action))
            skt_pkg::ACT_INSERT, skt_pkg::ACT_DELETE, skt_pkg::ACT_FIND: begin
              if (count_q == '0) begin
                slot_d  = '0;
                hit_d   = 1'b0;
                state_d = skt_pkg::S_DECIDE;
              end else begin
                ram_re_o    = 1'b1;
                ram_raddr_o = '0;
                ptr_d       = '0;
                state_d     = skt_pkg::S_SCAN;
              end
            end
            skt_pkg::ACT_NTH: begin
              if (count_q != '0 && CMP_W'(pos_eff) <= CMP_W'(count_q)) begin
                ram_re_o    = 1'b1;
                ram_raddr_o = IDX_W'(pos_eff - POS_W'(1));
                state_d     = skt_pkg::S_FETCH;
              end else begin
                status_d = skt_pkg::ST_BAD;
                state_d  = skt_pkg::S_DONE;
              end
            end
            skt_pkg::ACT_LAST: begin
              if (count_q != '0) begin
                ram_re_o    = 1'b1;
                ram_raddr_o = IDX_W'(last_cnt);
                state_d     = skt_pkg::S_FETCH;
              end else begin
                status_d = skt_pkg::ST_BAD;
                state_d  = skt_pkg::S_DONE;
              end
            end
            default: begin
              status_d = skt_pkg::ST_BAD;
              state_d  = skt_pkg::S_DONE;
            end
          endcase
        end
      end

      // One stored entry arrives per cycle; stop at the first key not below, or after the last entry.
      skt_pkg::S_SCAN: begin
        if (ram_rdata_i.key >= key_q) begin
          slot_d  = ptr_ext;
          hit_d   = (ram_rdata_i.key == key_q);
          fkey_d  = ram_rdata_i.key;
          fpay_d  = ram_rdata_i.payload;
          state_d = skt_pkg::S_DECIDE;
        end else if (ptr_ext == last_cnt) begin
          slot_d  = count_q;
          hit_d   = 1'b0;
          state_d = skt_pkg::S_DECIDE;
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = ptr_q + IDX_W'(1);
          ptr_d       = ptr_q + IDX_W'(1);
        end
      end

      skt_pkg::S_DECIDE: begin
        state_d = skt_pkg::S_DONE;
        case (act_q)
          skt_pkg::ACT_FIND: begin
            if (hit_q) begin
              status_d = skt_pkg::ST_OK;
            end else begin
              status_d = skt_pkg::ST_MISSING;
              fkey_d   = '0;
              fpay_d   = '0;
            end
          end
          skt_pkg::ACT_INSERT: begin
            if (hit_q) begin
              status_d = skt_pkg::ST_EXISTS;
            end else if (count_q >= CNT_W'(skt_pkg::CAPACITY)) begin
              status_d = skt_pkg::ST_FULL;
              fkey_d   = '0;
              fpay_d   = '0;
            end else if (slot_q == count_q) begin
              state_d = skt_pkg::S_WRNEW;
            end else begin
              // Move the tail up, starting from the last entry.
              ram_re_o    = 1'b1;
              ram_raddr_o = IDX_W'(last_cnt);
              ptr_d       = IDX_W'(last_cnt);
              state_d     = skt_pkg::S_SHUP;
            end
          end
          skt_pkg::ACT_DELETE: begin
            if (!hit_q) begin
              status_d = skt_pkg::ST_MISSING;
              fkey_d   = '0;
              fpay_d   = '0;
            end else begin
              status_d = skt_pkg::ST_OK;
              if (slot_q == last_cnt) begin
                count_d = last_cnt;
              end else begin
                // Move the tail down, starting just above the removed slot.
                ram_re_o    = 1'b1;
                ram_raddr_o = IDX_W'(slot_q + CNT_W'(1));
                ptr_d       = IDX_W'(slot_q + CNT_W'(1));
                state_d     = skt_pkg::S_SHDN;
              end
            end
          end
          default: begin
            status_d = skt_pkg::ST_BAD;
            fkey_d   = '0;
            fpay_d   = '0;
          end
        endcase
      end

      skt_pkg::S_FETCH: begin
        status_d = skt_pkg::ST_OK;
        fkey_d   = ram_rdata_i.key;
        fpay_d   = ram_rdata_i.payload;
        state_d  = skt_pkg::S_DONE;
      end

      // Entry read last cycle goes one slot up.
      skt_pkg::S_SHUP: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = ptr_q + IDX_W'(1);
        ram_wdata_o = ram_rdata_i;
        if (ptr_ext == slot_q) begin
          state_d = skt_pkg::S_WRNEW;
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = ptr_q - IDX_W'(1);
          ptr_d       = ptr_q - IDX_W'(1);
        end
      end

      skt_pkg::S_WRNEW: begin
        ram_we_o            = 1'b1;
        ram_waddr_o         = IDX_W'(slot_q);
        ram_wdata_o.key     = key_q;
        ram_wdata_o.payload = pay_q;
        count_d             = count_q + CNT_W'(1);
        status_d            = skt_pkg::ST_OK;
        fkey_d              = key_q;
        fpay_d              = pay_q;
        state_d             = skt_pkg::S_DONE;
      end

      // Entry read last cycle goes one slot down.
      skt_pkg::S_SHDN: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = ptr_q - IDX_W'(1);
        ram_wdata_o = ram_rdata_i;
        if (ptr_ext == last_cnt) begin
          count_d = last_cnt;
          state_d = skt_pkg::S_DONE;
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = ptr_q + IDX_W'(1);
          ptr_d       = ptr_q + IDX_W'(1);
        end
      end

      skt_pkg::S_DONE: begin
        if (res_ready_i) begin
          state_d = skt_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = skt_pkg::S_IDLE;
      end
    endcase
  end

  // Result as it stands once the item has finished.
  assign res_o.status  = status_q;
  assign res_o.key     = fkey_q;
  assign res_o.payload = fpay_q;
  assign res_o.count   = skt_pkg::ECNT_W'(count_q);

endmodule

// ===== src/skt_out.sv =====
module skt_out (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             res_valid_i,
  output logic             res_ready_o,
  input  skt_pkg::result_t res_i,
  skt_rsp_if.source        rsp_o
);

  logic             valid_q, valid_d;
  skt_pkg::result_t data_q;

  // The register takes a new result when empty or when its beat leaves.
  assign res_ready_o = !valid_q || rsp_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (res_ready_o) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign rsp_o.valid         = valid_q;
  assign rsp_o.status        = data_q.status;
  assign rsp_o.found_key     = data_q.key;
  assign rsp_o.found_payload = data_q.payload;
  assign rsp_o.entry_count   = data_q.count;

endmodule
